>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GBN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbn assertion failed");

// Next-cycle implication, disabled during reset.
`define GBN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbn assertion failed");

`endif

>>> src/gbn_pkg.sv
// Types, codes and constants of the go-back-n sender window unit.
package gbn_pkg;

  localparam int SEGMENT_BYTES_DEF = 1024;
  localparam int MAX_WINDOW_DEF    = 32;

  localparam int OP_W       = 2;
  localparam int SEQ_W      = 16;
  localparam int FLEN_W     = 24;
  localparam int WIN_W      = 6;
  localparam int TMO_W      = 20;
  localparam int KIND_W     = 2;
  localparam int SEGLEN_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [SEQ_W-1:0] SEQ_CAP     = 16'd65534;
  localparam logic [TMO_W-1:0] ELAPSED_MAX = 20'hFFFFF;
  localparam logic [WIN_W-1:0] WIN_RST     = 6'd10;
  localparam logic [TMO_W-1:0] TMO_RST     = 20'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_ACK   = 2'd1,
    OP_START = 2'd2
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NEW  = 2'd0,
    KIND_RETX = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEND,
    ST_RETX
  } ctrl_state_t;

  typedef struct packed {
    logic do_ack;
    logic do_start;
    logic eval;
    logic emit_send;
    logic emit_retx;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic complete;
    logic send_ok;
    logic send_more;
    logic retx_go;
    logic retx_nonempty;
    logic retx_pending;
    logic retx_more;
    logic out_free;
  } status_t;

endpackage

>>> src/gbn_ifs.sv
// Channel interfaces: input items, result items and configuration writes.
interface gbn_in_if;
  logic                        valid;
  logic                        ready;
  logic [gbn_pkg::OP_W-1:0]    opcode;
  logic [gbn_pkg::SEQ_W-1:0]   ack_number;
  logic                        ack_ok;
  modport source(output valid, output opcode, output ack_number, output ack_ok,
                 input ready);
  modport sink(input valid, input opcode, input ack_number, input ack_ok,
               output ready);
endinterface

interface gbn_out_if;
  logic                         valid;
  logic                         ready;
  logic [gbn_pkg::KIND_W-1:0]   kind;
  logic [gbn_pkg::SEQ_W-1:0]    seq_number;
  logic [gbn_pkg::FLEN_W-1:0]   byte_offset;
  logic [gbn_pkg::SEGLEN_W-1:0] seg_length;
  logic                         last;
  modport source(output valid, output kind, output seq_number, output byte_offset,
                 output seg_length, output last, input ready);
  modport sink(input valid, input kind, input seq_number, input byte_offset,
               input seg_length, input last, output ready);
endinterface

interface gbn_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gbn_pkg::CFG_IDX_W-1:0]  index;
  logic [gbn_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

>>> src/gbn_ctrl.sv
// Controller: takes input items and sequences the evaluation and result emission.
module gbn_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  gbn_in_if.sink           in_ch,
  input  gbn_pkg::status_t sts,
  output gbn_pkg::cmd_t    cmd
);

  gbn_pkg::ctrl_state_t state_r, state_nxt;

  assign in_ch.ready = (state_r == gbn_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      gbn_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.opcode)
            gbn_pkg::OP_TICK:  state_nxt    = gbn_pkg::ST_EVAL;
            gbn_pkg::OP_ACK:   cmd.do_ack   = 1'b1;
            gbn_pkg::OP_START: cmd.do_start = 1'b1;
            default: ;
          endcase
        end
      end
      gbn_pkg::ST_EVAL: begin
        if (sts.complete) begin
          // wait for the output slot, then report completion
          if (sts.out_free) begin
            cmd.emit_done = 1'b1;
            state_nxt     = gbn_pkg::ST_IDLE;
          end
        end else begin
          cmd.eval = 1'b1;
          priority if (sts.send_ok) begin
            state_nxt = gbn_pkg::ST_SEND;
          end else if (sts.retx_go && sts.retx_nonempty) begin
            state_nxt = gbn_pkg::ST_RETX;
          end else begin
            state_nxt = gbn_pkg::ST_IDLE;
          end
        end
      end
      gbn_pkg::ST_SEND: begin
        if (sts.out_free) begin
          cmd.emit_send = 1'b1;
          if (!sts.send_more) begin
            state_nxt = sts.retx_pending ? gbn_pkg::ST_RETX : gbn_pkg::ST_IDLE;
          end
        end
      end
      gbn_pkg::ST_RETX: begin
        if (sts.out_free) begin
          cmd.emit_retx = 1'b1;
          if (!sts.retx_more) begin
            state_nxt = gbn_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = gbn_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> src/gbn_dpath.sv
// Datapath: window pointers, timer, configuration registers and result register.
module gbn_dpath #(
  parameter int SEGMENT_BYTES = gbn_pkg::SEGMENT_BYTES_DEF,
  parameter int MAX_WINDOW    = gbn_pkg::MAX_WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gbn_pkg::cmd_t             cmd,
  output gbn_pkg::status_t          sts,
  input  logic [gbn_pkg::SEQ_W-1:0] ack_number,
  input  logic                      ack_ok,
  gbn_cfg_if.sink                   cfg_ch,
  gbn_out_if.source                 out_ch
);

  localparam int SEQ_W = gbn_pkg::SEQ_W;
  localparam int OFF_W = SEQ_W + $clog2(SEGMENT_BYTES);
  localparam int CMP_W = (OFF_W > gbn_pkg::FLEN_W) ? OFF_W : gbn_pkg::FLEN_W;
  localparam logic [CMP_W-1:0] SEG_STEP = CMP_W'(SEGMENT_BYTES);

  // configuration
  logic [gbn_pkg::WIN_W-1:0]  win_r;
  logic [gbn_pkg::FLEN_W-1:0] flen_r;
  logic [gbn_pkg::TMO_W-1:0]  tmo_r;

  // window state; the offsets track (pointer - 1) * segment size
  logic [SEQ_W-1:0]          base_r, base_nxt;
  logic [SEQ_W-1:0]          next_r, next_nxt;
  logic [CMP_W-1:0]          base_off_r, base_off_nxt;
  logic [CMP_W-1:0]          next_off_r, next_off_nxt;
  logic                      timer_r, timer_nxt;
  logic [gbn_pkg::TMO_W-1:0] elapsed_r, elapsed_nxt;
  logic [SEQ_W-1:0]          cur_r, cur_nxt;
  logic [CMP_W-1:0]          cur_off_r, cur_off_nxt;
  logic                      retx_pend_r, retx_pend_nxt;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  gbn_pkg::kind_t               out_kind_r, out_kind_nxt;
  logic [SEQ_W-1:0]             out_seq_r, out_seq_nxt;
  logic [gbn_pkg::FLEN_W-1:0]   out_off_r, out_off_nxt;
  logic [gbn_pkg::SEGLEN_W-1:0] out_len_r, out_len_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [gbn_pkg::WIN_W-1:0]  eff_win;
  logic [gbn_pkg::TMO_W-1:0]  tmo_eff;
  logic [SEQ_W:0]             limit;
  logic [SEQ_W:0]             next_inc;
  logic [CMP_W-1:0]           flen_ext;
  logic [gbn_pkg::TMO_W-1:0]  elapsed_inc;
  logic                       kick_timer;
  logic                       fire;
  logic                       ack_hit;
  logic [SEQ_W-1:0]           ack_inc;
  logic [CMP_W-1:0]           emit_off;
  logic [CMP_W-1:0]           gap;
  logic [CMP_W-1:0]           emit_len;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= gbn_pkg::WIN_RST;
      flen_r <= '0;
      tmo_r  <= gbn_pkg::TMO_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        gbn_pkg::REG_WINDOW_SIZE:   win_r  <= cfg_ch.data[gbn_pkg::WIN_W-1:0];
        gbn_pkg::REG_FILE_LENGTH:   flen_r <= cfg_ch.data[gbn_pkg::FLEN_W-1:0];
        gbn_pkg::REG_TIMEOUT_TICKS: tmo_r  <= cfg_ch.data[gbn_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (win_r == '0) begin
      eff_win = gbn_pkg::WIN_W'(1);
    end else if (32'(win_r) > MAX_WINDOW) begin
      eff_win = gbn_pkg::WIN_W'(MAX_WINDOW);
    end else begin
      eff_win = win_r;
    end
  end

  assign tmo_eff  = (tmo_r == '0) ? gbn_pkg::TMO_W'(1) : tmo_r;
  assign limit    = {1'b0, base_r} + (SEQ_W + 1)'(eff_win);
  assign next_inc = {1'b0, next_r} + (SEQ_W + 1)'(1);
  assign flen_ext = CMP_W'(flen_r);

  // status toward the controller
  assign sts.complete      = (base_r > gbn_pkg::SEQ_CAP) || (base_off_r >= flen_ext);
  assign sts.send_ok       = ({1'b0, next_r} < limit) && (next_r <= gbn_pkg::SEQ_CAP)
                             && (next_off_r < flen_ext);
  assign sts.send_more     = (next_inc < limit)
                             && (next_inc <= (SEQ_W + 1)'(gbn_pkg::SEQ_CAP))
                             && ((next_off_r + SEG_STEP) < flen_ext);
  assign sts.retx_nonempty = (base_r != next_r);
  assign sts.retx_pending  = retx_pend_r;
  assign sts.retx_more     = ((cur_r + SEQ_W'(1)) != next_r);
  assign sts.out_free      = !out_valid_r || out_ch.ready;

  // tick evaluation: age the timer, start it if the first send opens the window
  assign elapsed_inc = (timer_r && (elapsed_r != gbn_pkg::ELAPSED_MAX))
                       ? elapsed_r + gbn_pkg::TMO_W'(1) : elapsed_r;
  assign kick_timer  = sts.send_ok && (base_r == next_r);
  assign fire        = timer_r && (elapsed_inc >= tmo_eff);
  assign sts.retx_go = fire && !kick_timer;

  assign ack_hit = ack_ok && (ack_number >= base_r) && (ack_number < next_r);
  assign ack_inc = ack_number + SEQ_W'(1);

  // segment length of the result being emitted
  assign emit_off = cmd.emit_send ? next_off_r : cur_off_r;
  assign gap      = flen_ext - emit_off;
  always_comb begin
    if (emit_off < flen_ext) begin
      emit_len = (gap > SEG_STEP) ? SEG_STEP : gap;
    end else begin
      emit_len = '0;
    end
  end

  always_comb begin
    base_nxt      = base_r;
    next_nxt      = next_r;
    base_off_nxt  = base_off_r;
    next_off_nxt  = next_off_r;
    timer_nxt     = timer_r;
    elapsed_nxt   = elapsed_r;
    cur_nxt       = cur_r;
    cur_off_nxt   = cur_off_r;
    retx_pend_nxt = retx_pend_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_seq_nxt   = out_seq_r;
    out_off_nxt   = out_off_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;

    if (cmd.do_start) begin
      base_nxt     = SEQ_W'(1);
      next_nxt     = SEQ_W'(1);
      base_off_nxt = '0;
      next_off_nxt = '0;
      timer_nxt    = 1'b0;
      elapsed_nxt  = '0;
    end

    if (cmd.do_ack && ack_hit) begin
      base_nxt     = ack_inc;
      base_off_nxt = CMP_W'(ack_number) * SEG_STEP;
      if (ack_inc == next_r) begin
        timer_nxt = 1'b0;
      end else begin
        timer_nxt   = 1'b1;
        elapsed_nxt = '0;
      end
    end

    if (cmd.eval) begin
      timer_nxt     = timer_r || kick_timer;
      elapsed_nxt   = (kick_timer || fire) ? '0 : elapsed_inc;
      retx_pend_nxt = sts.retx_go;
      cur_nxt       = base_r;
      cur_off_nxt   = base_off_r;
    end

    if (cmd.emit_send) begin
      next_nxt      = next_inc[SEQ_W-1:0];
      next_off_nxt  = next_off_r + SEG_STEP;
      out_valid_nxt = 1'b1;
      out_kind_nxt  = gbn_pkg::KIND_NEW;
      out_seq_nxt   = next_r;
      out_off_nxt   = next_off_r[gbn_pkg::FLEN_W-1:0];
      out_len_nxt   = emit_len[gbn_pkg::SEGLEN_W-1:0];
      out_last_nxt  = !sts.send_more && !retx_pend_r;
    end

    if (cmd.emit_retx) begin
      cur_nxt       = cur_r + SEQ_W'(1);
      cur_off_nxt   = cur_off_r + SEG_STEP;
      out_valid_nxt = 1'b1;
      out_kind_nxt  = gbn_pkg::KIND_RETX;
      out_seq_nxt   = cur_r;
      out_off_nxt   = cur_off_r[gbn_pkg::FLEN_W-1:0];
      out_len_nxt   = emit_len[gbn_pkg::SEGLEN_W-1:0];
      out_last_nxt  = !sts.retx_more;
    end

    if (cmd.emit_done) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = gbn_pkg::KIND_DONE;
      out_seq_nxt   = '0;
      out_off_nxt   = '0;
      out_len_nxt   = '0;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= SEQ_W'(1);
      next_r      <= SEQ_W'(1);
      base_off_r  <= '0;
      next_off_r  <= '0;
      timer_r     <= 1'b0;
      elapsed_r   <= '0;
      retx_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      base_off_r  <= base_off_nxt;
      next_off_r  <= next_off_nxt;
      timer_r     <= timer_nxt;
      elapsed_r   <= elapsed_nxt;
      retx_pend_r <= retx_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    cur_off_r  <= cur_off_nxt;
    out_kind_r <= out_kind_nxt;
    out_seq_r  <= out_seq_nxt;
    out_off_r  <= out_off_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.seq_number  = out_seq_r;
  assign out_ch.byte_offset = out_off_r;
  assign out_ch.seg_length  = out_len_r;
  assign out_ch.last        = out_last_r;

endmodule

>>> src/go_back_n_sender_window_unit.sv
// Go-back-N sender window unit. An acknowledgment, a start or an unused opcode
// is acted on in its accepting cycle, and the unit is ready again on the next.
// A tick is followed by an evaluation step and then one result per cycle while
// the result channel takes items: new sends up to the window, then retransmits
// of the outstanding segments, at most 2 * MAX_WINDOW results; a tick that finds
// the transfer complete yields a single completion result instead. The unit has
// a single result register; the last result of an item sits in that register
// while the next item is taken. Configuration writes are always accepted and
// must only be made while the unit is idle.
module go_back_n_sender_window_unit #(
  parameter int SEGMENT_BYTES = gbn_pkg::SEGMENT_BYTES_DEF,
  parameter int MAX_WINDOW    = gbn_pkg::MAX_WINDOW_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gbn_in_if.sink    in_ch,
  gbn_out_if.source out_ch,
  gbn_cfg_if.sink   cfg_ch
);

  gbn_pkg::cmd_t    cmd;
  gbn_pkg::status_t sts;

  gbn_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .sts   (sts),
    .cmd   (cmd)
  );

  gbn_dpath #(
    .SEGMENT_BYTES (SEGMENT_BYTES),
    .MAX_WINDOW    (MAX_WINDOW)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .ack_number (in_ch.ack_number),
    .ack_ok     (in_ch.ack_ok),
    .cfg_ch     (cfg_ch),
    .out_ch     (out_ch)
  );

endmodule

>>> src/gbn_chk.sv
// Port-level checker for the go-back-n sender window unit, with its bind.
`include "assert_macros.svh"

module gbn_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [gbn_pkg::KIND_W-1:0]       out_kind,
  input logic [gbn_pkg::SEQ_W-1:0]        out_seq,
  input logic [gbn_pkg::FLEN_W-1:0]       out_off,
  input logic [gbn_pkg::SEGLEN_W-1:0]     out_len,
  input logic                             out_last
);

  // a stalled item holds
  `GBN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_seq) && $stable(out_kind) && $stable(out_last))

  // completion carries no segment and ends its item
  `GBN_ASSERT_IMP(a_done_shape, clk, rst_n, out_valid && (out_kind == gbn_pkg::KIND_DONE), (out_seq == '0) && (out_off == '0) && (out_len == '0) && out_last)

  // segment results number from one
  `GBN_ASSERT_IMP(a_seq_nonzero, clk, rst_n, out_valid && (out_kind != gbn_pkg::KIND_DONE), out_seq != '0)

  // no new item is taken while the current one still has results to come
  `GBN_ASSERT_IMP(a_no_take_midburst, clk, rst_n, out_valid && !out_last, !in_ready)

endmodule

bind go_back_n_sender_window_unit gbn_chk u_gbn_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_seq   (out_ch.seq_number),
  .out_off   (out_ch.byte_offset),
  .out_len   (out_ch.seg_length),
  .out_last  (out_ch.last)
);
